// ----- hw/rtl/lwbc_pkg.sv -----
// shared types, constants and helpers of the layer window blend compositor
`default_nettype none

package lwbc_pkg;

	localparam int SCREEN_WIDTH = 240;
	localparam int SCREEN_HEIGHT = 160;
	localparam int CLIP_COLUMN = 240;

	localparam int IN_BITS = 104;
	localparam int OUT_BITS = 24;

	typedef logic [2:0] layer_t;
	localparam layer_t LAYER_SPRITE = 3'd4;
	localparam layer_t LAYER_BACKDROP = 3'd5;

	typedef enum logic [2:0] {
		REG_LAYER_ENABLE,
		REG_BG_PRIORITIES,
		REG_BLEND_CONTROL,
		REG_BLEND_COEFFS,
		REG_WIN0_BOUNDS,
		REG_WIN1_BOUNDS,
		REG_WINDOW_CONTROLS,
		REG_BACKDROP_COLOR
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FX_NONE,
		FX_ALPHA,
		FX_BRIGHTEN,
		FX_DARKEN
	} effect_t;

	typedef struct packed {
		logic [6:0]  layer_enable;
		logic [7:0]  bg_priorities;
		logic [13:0] blend_control;
		logic [14:0] blend_coeffs;
		logic [31:0] win0_bounds;
		logic [31:0] win1_bounds;
		logic [17:0] window_controls;
		logic [14:0] fill_color;
	} cfg_t;

	typedef struct packed {
		logic [23:0] front_color;
		logic [23:0] bot_color;
		layer_t      front_layer;
		layer_t      bot_layer;
	} layer_pick_t;

	function automatic logic [23:0] widen555(input logic [14:0] c);
		return {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
	endfunction

	function automatic logic [4:0] cap16(input logic [4:0] v);
		return (v > 5'd16) ? 5'd16 : v;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/layer_window_blend_compositor.sv -----
// top level of the layer window blend compositor
`default_nettype none

// Composites one pixel per clock unless m_tready holds the output: each
// transaction carries the four background colors, the sprite color and its
// priority for one screen position, and gives one 24-bit color. Each pixel
// passes the input register and then the result register, with window test, layer
// selection and the color effect in the single logic stage between them. The
// result register lets a new pixel enter while a finished one waits on m_tready.
// Configuration writes are taken every cycle and should happen only while idle.

module layer_window_blend_compositor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// line, x, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, sprite_pixel,
	// sprite_priority, zero pad
	input  wire logic [103:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pixel_color
	output logic [23:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	lwbc_pkg::cfg_t        cfg;
	lwbc_pkg::layer_pick_t pick;
	logic [5:0]            mask;
	logic [23:0]           color;

	logic                  valid_s1;
	logic [7:0]            line_s1, x_s1;
	logic [3:0][15:0]      bg_s1;
	logic [15:0]           sprite_s1;
	logic [1:0]            spri_s1;
	logic                  valid_s2;
	logic [23:0]           color_s2;
	logic                  adv;

	assign adv = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			line_s1 <= s_tdata[7:0];
			x_s1 <= s_tdata[15:8];
			bg_s1[0] <= s_tdata[31:16];
			bg_s1[1] <= s_tdata[47:32];
			bg_s1[2] <= s_tdata[63:48];
			bg_s1[3] <= s_tdata[79:64];
			sprite_s1 <= s_tdata[95:80];
			spri_s1 <= s_tdata[97:96];
		end
		if (adv && valid_s1) color_s2 <= color;
	end

	lwbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lwbc_window u_window (
		.cfg  (cfg),
		.line (line_s1),
		.x    (x_s1),
		.mask (mask)
	);

	lwbc_layer_sel u_layer_sel (
		.cfg             (cfg),
		.mask            (mask),
		.bg_pixel        (bg_s1),
		.sprite_pixel    (sprite_s1),
		.sprite_priority (spri_s1),
		.pick            (pick)
	);

	lwbc_blend u_blend (
		.cfg   (cfg),
		.pick  (pick),
		.fx_en (mask[5]),
		.x     (x_s1),
		.color (color)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = color_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/lwbc_cfg.sv -----
// configuration register file
`default_nettype none

module lwbc_cfg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	output lwbc_pkg::cfg_t        cfg
);

	lwbc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (lwbc_pkg::cfg_reg_t'(cfg_index))
				lwbc_pkg::REG_LAYER_ENABLE:    cfg_q.layer_enable <= cfg_data[6:0];
				lwbc_pkg::REG_BG_PRIORITIES:   cfg_q.bg_priorities <= cfg_data[7:0];
				lwbc_pkg::REG_BLEND_CONTROL:   cfg_q.blend_control <= cfg_data[13:0];
				lwbc_pkg::REG_BLEND_COEFFS:    cfg_q.blend_coeffs <= cfg_data[14:0];
				lwbc_pkg::REG_WIN0_BOUNDS:     cfg_q.win0_bounds <= cfg_data;
				lwbc_pkg::REG_WIN1_BOUNDS:     cfg_q.win1_bounds <= cfg_data;
				lwbc_pkg::REG_WINDOW_CONTROLS: cfg_q.window_controls <= cfg_data[17:0];
				lwbc_pkg::REG_BACKDROP_COLOR:  cfg_q.fill_color <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lwbc_window.sv -----
// window hit test and control mask selection
`default_nettype none

module lwbc_window (
	input  wire lwbc_pkg::cfg_t   cfg,
	input  wire logic [7:0]       line,
	input  wire logic [7:0]       x,
	output logic [5:0]            mask
);

	localparam logic [8:0] WIDTH_LIM = 9'(lwbc_pkg::SCREEN_WIDTH);
	localparam logic [8:0] HEIGHT_LIM = 9'(lwbc_pkg::SCREEN_HEIGHT);

	function automatic logic window_hit(input logic [31:0] bounds, input logic [7:0] ln,
			input logic [7:0] px);
		logic [8:0] right, left, bottom, top, ln9, px9;
		logic       in_v, in_h;
		right = {1'b0, bounds[7:0]};
		left = {1'b0, bounds[15:8]};
		bottom = {1'b0, bounds[23:16]};
		top = {1'b0, bounds[31:24]};
		ln9 = {1'b0, ln};
		px9 = {1'b0, px};
		if (right > WIDTH_LIM) right = WIDTH_LIM;
		if (bottom > HEIGHT_LIM) bottom = HEIGHT_LIM;
		in_v = (top <= bottom) && (ln9 >= top) && (ln9 < bottom);
		// left past right means the span wraps around the line end
		if (left > right) in_h = (px9 >= left) || (px9 < right);
		else in_h = (px9 >= left) && (px9 < right);
		return in_v && in_h;
	endfunction

	logic w0_en, w1_en;

	assign w0_en = cfg.layer_enable[5];
	assign w1_en = cfg.layer_enable[6];

	always_comb begin
		mask = 6'h3F;
		if (w0_en || w1_en) begin
			mask = cfg.window_controls[17:12];
			if (w1_en && window_hit(cfg.win1_bounds, line, x)) mask = cfg.window_controls[11:6];
			if (w0_en && window_hit(cfg.win0_bounds, line, x)) mask = cfg.window_controls[5:0];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lwbc_layer_sel.sv -----
// picks the top and second visible opaque layers by priority
`default_nettype none

module lwbc_layer_sel (
	input  wire lwbc_pkg::cfg_t       cfg,
	input  wire logic [5:0]           mask,
	input  wire logic [3:0][15:0]     bg_pixel,
	input  wire logic [15:0]          sprite_pixel,
	input  wire logic [1:0]           sprite_priority,
	output lwbc_pkg::layer_pick_t     pick
);

	// layers 0-3 are backgrounds, layer 4 the sprite
	logic [4:0]       elig;
	logic [4:0][4:0]  key;
	logic [4:0][2:0]  rank;
	logic [4:0][15:0] pix;
	logic [23:0]      back;

	always_comb begin
		pix[0] = bg_pixel[0];
		pix[1] = bg_pixel[1];
		pix[2] = bg_pixel[2];
		pix[3] = bg_pixel[3];
		pix[4] = sprite_pixel;
		for (int l = 0; l < 4; l++) begin
			elig[l] = cfg.layer_enable[l] && mask[l] && pix[l][15];
			// sprite goes ahead of backgrounds at equal priority
			key[l] = {cfg.bg_priorities[2*l +: 2], 3'(l + 1)};
		end
		elig[4] = cfg.layer_enable[4] && mask[4] && sprite_pixel[15];
		key[4] = {sprite_priority, 3'd0};
	end

	always_comb begin
		for (int l = 0; l < 5; l++) begin
			rank[l] = 3'd0;
			for (int j = 0; j < 5; j++) begin
				if (elig[j] && (key[j] < key[l])) rank[l] = rank[l] + 3'd1;
			end
		end
	end

	assign back = lwbc_pkg::widen555(cfg.fill_color);

	always_comb begin
		pick.front_color = back;
		pick.bot_color = back;
		pick.front_layer = lwbc_pkg::LAYER_BACKDROP;
		pick.bot_layer = lwbc_pkg::LAYER_BACKDROP;
		for (int l = 0; l < 5; l++) begin
			if (elig[l] && rank[l] == 3'd0) begin
				pick.front_color = lwbc_pkg::widen555(pix[l][14:0]);
				pick.front_layer = 3'(l);
			end
			if (elig[l] && rank[l] == 3'd1) begin
				pick.bot_color = lwbc_pkg::widen555(pix[l][14:0]);
				pick.bot_layer = 3'(l);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lwbc_blend.sv -----
// color effects: alpha blend, brighten, darken, plus clip column
`default_nettype none

module lwbc_blend (
	input  wire lwbc_pkg::cfg_t        cfg,
	input  wire lwbc_pkg::layer_pick_t pick,
	input  wire logic                  fx_en,
	input  wire logic [7:0]            x,
	output logic [23:0]                color
);

	localparam logic [8:0] CLIP_LIM = 9'(lwbc_pkg::CLIP_COLUMN);

	logic [4:0]  eva, evb, evy;
	logic [5:0]  first_mask, second_mask;
	logic        first, second;
	logic [23:0] alpha_c, bright_c, dark_c, fx_c;

	assign eva = lwbc_pkg::cap16(cfg.blend_coeffs[4:0]);
	assign evb = lwbc_pkg::cap16(cfg.blend_coeffs[9:5]);
	assign evy = lwbc_pkg::cap16(cfg.blend_coeffs[14:10]);
	assign first_mask = cfg.blend_control[5:0];
	assign second_mask = cfg.blend_control[13:8];
	assign first = first_mask[pick.front_layer];
	assign second = second_mask[pick.bot_layer];

	always_comb begin
		logic [7:0]  t, b;
		logic [12:0] sum, inc, dec;
		for (int k = 0; k < 3; k++) begin
			t = pick.front_color[8*k +: 8];
			b = pick.bot_color[8*k +: 8];
			sum = ({5'd0, t} * {8'd0, eva}) + ({5'd0, b} * {8'd0, evb});
			alpha_c[8*k +: 8] = (sum[12:4] > 9'd255) ? 8'd255 : sum[11:4];
			// brighten stays within 255 since the step is a fraction of the headroom
			inc = {5'd0, 8'd255 - t} * {8'd0, evy};
			bright_c[8*k +: 8] = t + inc[11:4];
			dec = {5'd0, t} * {8'd0, evy};
			dark_c[8*k +: 8] = t - dec[11:4];
		end
	end

	always_comb begin
		fx_c = pick.front_color;
		if (fx_en) begin
			case (lwbc_pkg::effect_t'(cfg.blend_control[7:6]))
				lwbc_pkg::FX_ALPHA:    if (first && second) fx_c = alpha_c;
				lwbc_pkg::FX_BRIGHTEN: if (first) fx_c = bright_c;
				lwbc_pkg::FX_DARKEN:   if (first) fx_c = dark_c;
				default: ;
			endcase
		end
	end

	assign color = ({1'b0, x} >= CLIP_LIM) ? 24'd0 : fx_c;

endmodule

`default_nettype wire

// ----- tb/composite_checker.sv -----
// checker for the layer window blend compositor: pixel predictor and result compare
`timescale 1ns / 1ps

module composite_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [103:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [23:0]  m_tdata,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                mismatches,
	output int                results_seen,
	output int                backlog
);

	lwbc_pkg::cfg_t shadow_cfg;
	logic [23:0] expected_colors[$];

	function automatic logic [23:0] expand_rgb555(logic [14:0] c);
		logic [23:0] rgb;
		int k;
		for (k = 0; k < 3; k++)
			rgb[8*k +: 8] = {c[5*k +: 5], 3'b000};
		return rgb;
	endfunction

	function automatic int limit_coeff(logic [4:0] v);
		return (v > 16) ? 16 : int'(v);
	endfunction

	// rows top..bottom-1, columns left..right-1, wrapping when left passes right
	function automatic bit in_window(logic [31:0] b, int row, int col);
		int right, left, bottom, top_row;
		right = int'(b[7:0]);
		left = int'(b[15:8]);
		bottom = int'(b[23:16]);
		top_row = int'(b[31:24]);
		if (right > lwbc_pkg::SCREEN_WIDTH) right = lwbc_pkg::SCREEN_WIDTH;
		if (bottom > lwbc_pkg::SCREEN_HEIGHT) bottom = lwbc_pkg::SCREEN_HEIGHT;
		if (top_row > bottom || row < top_row || row >= bottom) return 1'b0;
		if (left > right) return col >= left || col < right;
		return col >= left && col < right;
	endfunction

	function automatic logic [23:0] composite_pixel(lwbc_pkg::cfg_t c, logic [103:0] d);
		int row, col, pri, i, k, t, u, eva, evb, evy;
		logic [15:0] bg_pix[4];
		logic [15:0] spr;
		logic [1:0] spr_pri;
		logic [5:0] mask;
		logic [23:0] top_c, bot_c;
		lwbc_pkg::layer_t top_l, bot_l;
		bit have_front, found_bot, first, second;
		lwbc_pkg::effect_t fx;

		row = int'(d[7:0]);
		col = int'(d[15:8]);
		for (i = 0; i < 4; i++) bg_pix[i] = d[16 + 16*i +: 16];
		spr = d[95:80];
		spr_pri = d[97:96];

		mask = 6'h3F;
		if (c.layer_enable[5] || c.layer_enable[6]) begin
			mask = c.window_controls[17:12];
			if (c.layer_enable[6] && in_window(c.win1_bounds, row, col))
				mask = c.window_controls[11:6];
			if (c.layer_enable[5] && in_window(c.win0_bounds, row, col))
				mask = c.window_controls[5:0];
		end

		top_c = expand_rgb555(c.fill_color);
		bot_c = top_c;
		top_l = lwbc_pkg::LAYER_BACKDROP;
		bot_l = lwbc_pkg::LAYER_BACKDROP;
		have_front = 1'b0;
		found_bot = 1'b0;
		// sprite wins ties, then backgrounds by ascending index
		for (pri = 0; pri < 4 && !found_bot; pri++) begin
			if (c.layer_enable[4] && mask[4] && spr[15] && spr_pri == pri) begin
				if (!have_front) begin
					top_c = expand_rgb555(spr[14:0]);
					top_l = lwbc_pkg::LAYER_SPRITE;
					have_front = 1'b1;
				end else begin
					bot_c = expand_rgb555(spr[14:0]);
					bot_l = lwbc_pkg::LAYER_SPRITE;
					found_bot = 1'b1;
				end
			end
			for (i = 0; i < 4 && !found_bot; i++) begin
				if (c.layer_enable[i] && mask[i] && c.bg_priorities[2*i +: 2] == pri &&
						bg_pix[i][15]) begin
					if (!have_front) begin
						top_c = expand_rgb555(bg_pix[i][14:0]);
						top_l = lwbc_pkg::layer_t'(i);
						have_front = 1'b1;
					end else begin
						bot_c = expand_rgb555(bg_pix[i][14:0]);
						bot_l = lwbc_pkg::layer_t'(i);
						found_bot = 1'b1;
					end
				end
			end
		end

		if (mask[5]) begin
			fx = lwbc_pkg::effect_t'(c.blend_control[7:6]);
			first = c.blend_control[top_l];
			second = c.blend_control[8 + bot_l];
			eva = limit_coeff(c.blend_coeffs[4:0]);
			evb = limit_coeff(c.blend_coeffs[9:5]);
			evy = limit_coeff(c.blend_coeffs[14:10]);
			for (k = 0; k < 3; k++) begin
				t = int'(top_c[8*k +: 8]);
				u = int'(bot_c[8*k +: 8]);
				case (fx)
					lwbc_pkg::FX_ALPHA:    if (first && second) t = (t * eva + u * evb) / 16;
					lwbc_pkg::FX_BRIGHTEN: if (first) t = t + ((255 - t) * evy) / 16;
					lwbc_pkg::FX_DARKEN:   if (first) t = t - (t * evy) / 16;
					default: ;
				endcase
				if (t > 255) t = 255;
				top_c[8*k +: 8] = t[7:0];
			end
		end

		return (col >= lwbc_pkg::CLIP_COLUMN) ? 24'd0 : top_c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg = '0;
			expected_colors.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			// register updates land before a pixel accepted on the same edge is computed
			if (cfg_valid && cfg_ready) begin
				case (lwbc_pkg::cfg_reg_t'(cfg_index))
					lwbc_pkg::REG_LAYER_ENABLE:    shadow_cfg.layer_enable = cfg_data[6:0];
					lwbc_pkg::REG_BG_PRIORITIES:   shadow_cfg.bg_priorities = cfg_data[7:0];
					lwbc_pkg::REG_BLEND_CONTROL:   shadow_cfg.blend_control = cfg_data[13:0];
					lwbc_pkg::REG_BLEND_COEFFS:    shadow_cfg.blend_coeffs = cfg_data[14:0];
					lwbc_pkg::REG_WIN0_BOUNDS:     shadow_cfg.win0_bounds = cfg_data;
					lwbc_pkg::REG_WIN1_BOUNDS:     shadow_cfg.win1_bounds = cfg_data;
					lwbc_pkg::REG_WINDOW_CONTROLS: shadow_cfg.window_controls = cfg_data[17:0];
					lwbc_pkg::REG_BACKDROP_COLOR:  shadow_cfg.fill_color = cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_colors.push_back(composite_pixel(shadow_cfg, s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_colors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel_color %06h arrived with no pixel outstanding", m_tdata);
				end else if (expected_colors[0] !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel_color mismatch: expected %06h, got %06h",
							expected_colors[0], m_tdata);
					void'(expected_colors.pop_front());
				end else begin
					void'(expected_colors.pop_front());
				end
			end
		end
		backlog = expected_colors.size();
	end

endmodule

// ----- tb/layer_window_blend_compositor_tb.sv -----
// testbench top for the layer window blend compositor: stimulus, reset and verdict
`timescale 1ns / 1ps

module layer_window_blend_compositor_tb;

	typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_SPARSE} ready_pattern_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// line, x, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel, sprite_pixel,
	// sprite_priority, zero pad
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// pixel_color
	logic [23:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int mismatches, results_seen, backlog;
	int pixels_sent = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	ready_pattern_t ready_pattern = READY_ALWAYS;
	int stall_tick = 0;

	layer_window_blend_compositor u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	composite_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .results_seen(results_seen), .backlog(backlog)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		case (ready_pattern)
			READY_ALWAYS:   m_tready <= 1'b1;
			READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
			READY_PERIODIC: m_tready <= (stall_tick % 7) < 3;
			default:        m_tready <= ($urandom_range(0, 7) == 0);
		endcase
		stall_tick <= stall_tick + 1;
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [103:0] pack_pixel(logic [7:0] row, logic [7:0] col,
			logic [15:0] bg0, logic [15:0] bg1, logic [15:0] bg2, logic [15:0] bg3,
			logic [15:0] spr, logic [1:0] spr_pri);
		return {6'b0, spr_pri, spr, bg3, bg2, bg1, bg0, col, row};
	endfunction

	function automatic lwbc_pkg::cfg_t make_setup(logic [6:0] le, logic [7:0] pri,
			logic [13:0] bc, logic [14:0] co, logic [31:0] w0, logic [31:0] w1,
			logic [17:0] wc, logic [14:0] bd);
		lwbc_pkg::cfg_t c;
		c.layer_enable = le;
		c.bg_priorities = pri;
		c.blend_control = bc;
		c.blend_coeffs = co;
		c.win0_bounds = w0;
		c.win1_bounds = w1;
		c.window_controls = wc;
		c.fill_color = bd;
		return c;
	endfunction

	// windows mostly land on screen so the masks get exercised
	function automatic logic [31:0] random_bounds();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return {8'($urandom_range(0, 120)), 8'($urandom_range(40, 200)),
			8'($urandom_range(0, 200)), 8'($urandom_range(20, 255))};
	endfunction

	function automatic lwbc_pkg::cfg_t random_setup();
		return make_setup(7'($urandom), 8'($urandom), 14'($urandom), 15'($urandom),
			random_bounds(), random_bounds(), 18'($urandom), 15'($urandom));
	endfunction

	function automatic logic [103:0] random_pixel();
		logic [15:0] layer_pix[5];
		int k;
		for (k = 0; k < 5; k++) layer_pix[k] = {$urandom_range(0, 3) != 0, 15'($urandom)};
		return pack_pixel(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 170)),
			8'($urandom), layer_pix[0], layer_pix[1], layer_pix[2], layer_pix[3],
			layer_pix[4], 2'($urandom));
	endfunction

	// leaves cfg_valid high; program_regs drops it after the last transaction
	task automatic write_reg(lwbc_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(lwbc_pkg::cfg_t c);
		write_reg(lwbc_pkg::REG_LAYER_ENABLE, 32'(c.layer_enable));
		write_reg(lwbc_pkg::REG_BG_PRIORITIES, 32'(c.bg_priorities));
		write_reg(lwbc_pkg::REG_BLEND_CONTROL, 32'(c.blend_control));
		write_reg(lwbc_pkg::REG_BLEND_COEFFS, 32'(c.blend_coeffs));
		write_reg(lwbc_pkg::REG_WIN0_BOUNDS, c.win0_bounds);
		write_reg(lwbc_pkg::REG_WIN1_BOUNDS, c.win1_bounds);
		write_reg(lwbc_pkg::REG_WINDOW_CONTROLS, 32'(c.window_controls));
		write_reg(lwbc_pkg::REG_BACKDROP_COLOR, 32'(c.fill_color));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [103:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// every pixel yields a color, so the block is idle once all have come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_seen != pixels_sent) @(posedge clk);
	endtask

	initial begin
		lwbc_pkg::cfg_t setup;
		int p, n;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: backdrop black, pixel past the clip column
		send_pixel(pack_pixel(8'd0, 8'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000,
			16'hFFFF, 2'd0));
		send_pixel(pack_pixel(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 2'd3));
		drain();

		// no windows, equal priorities, saturating alpha blend
		program_regs(make_setup(7'h1F, 8'h00, {6'h3F, lwbc_pkg::FX_ALPHA, 6'h3F},
			{5'd0, 5'd31, 5'd31}, 32'h0, 32'h0, 18'h0, 15'h7FFF));
		send_pixel(pack_pixel(8'd5, 8'd7, 16'h801F, 16'h83E0, 16'hFC00, 16'hFFFF,
			16'hAAAA, 2'd0));
		send_pixel(pack_pixel(8'd5, 8'd8, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 2'd0));
		send_pixel(pack_pixel(8'd5, 8'd9, 16'h0000, 16'h9234, 16'hC567, 16'h0000,
			16'h0000, 2'd1));
		send_pixel(pack_pixel(8'd5, 8'd10, 16'h0000, 16'h0000, 16'h0000, 16'h8421,
			16'hD555, 2'd3));
		send_pixel(pack_pixel(8'd5, 8'd240, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 2'd0));
		drain();

		// reversed background priorities, full brighten
		program_regs(make_setup(7'h1F, 8'b00_01_10_11, {6'h00, lwbc_pkg::FX_BRIGHTEN, 6'h3F},
			{5'd16, 5'd0, 5'd0}, 32'h0, 32'h0, 18'h0, 15'h1234));
		send_pixel(pack_pixel(8'd0, 8'd239, 16'h8421, 16'h8842, 16'h9084, 16'hA108,
			16'h0000, 2'd0));
		send_pixel(pack_pixel(8'd1, 8'd1, 16'h8421, 16'h8842, 16'h9084, 16'hA108,
			16'hC210, 2'd0));
		send_pixel(pack_pixel(8'd2, 8'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 2'd2));
		drain();

		// darken with only the sprite as first target
		program_regs(make_setup(7'h1F, 8'h00, {6'h00, lwbc_pkg::FX_DARKEN, 6'h10},
			{5'd8, 5'd0, 5'd0}, 32'h0, 32'h0, 18'h0, 15'h0));
		send_pixel(pack_pixel(8'd3, 8'd3, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 2'd0));
		send_pixel(pack_pixel(8'd3, 8'd4, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 2'd1));
		drain();

		// wrapping window 0 over clamped window 1 over outside
		program_regs(make_setup(7'h7F, 8'h00, {6'h3F, lwbc_pkg::FX_ALPHA, 6'h3F},
			{5'd0, 5'd8, 5'd8}, {8'd10, 8'd20, 8'd200, 8'd50}, {8'd0, 8'd255, 8'd0, 8'd255},
			{6'h2F, 6'h30, 6'h01}, 15'h03E0));
		send_pixel(pack_pixel(8'd15, 8'd210, 16'h801F, 16'h83E0, 16'h8000, 16'h8000,
			16'hFC00, 2'd0));
		send_pixel(pack_pixel(8'd15, 8'd100, 16'h801F, 16'h83E0, 16'h8000, 16'h8000,
			16'hFC00, 2'd0));
		send_pixel(pack_pixel(8'd15, 8'd10, 16'h801F, 16'h83E0, 16'h8000, 16'h8000,
			16'hFC00, 2'd0));
		send_pixel(pack_pixel(8'd200, 8'd100, 16'h801F, 16'h83E0, 16'h8000, 16'h8000,
			16'hFC00, 2'd0));
		send_pixel(pack_pixel(8'd100, 8'd245, 16'h801F, 16'h83E0, 16'h8000, 16'h8000,
			16'hFC00, 2'd0));
		drain();

		// window 1 alone with top below bottom never hits
		program_regs(make_setup(7'h5F, 8'h1B, {6'h3F, lwbc_pkg::FX_ALPHA, 6'h3F},
			{5'd0, 5'd4, 5'd12}, 32'h0, {8'd50, 8'd20, 8'd0, 8'd255},
			{6'h0F, 6'h3F, 6'h00}, 15'h7C00));
		send_pixel(pack_pixel(8'd30, 8'd30, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 2'd0));
		send_pixel(pack_pixel(8'd60, 8'd120, 16'h8123, 16'h8456, 16'h8789, 16'h8ABC,
			16'h8DEF, 2'd2));
		drain();

		for (p = 0; p < 13; p++) begin
			if (p == 0) setup = make_setup('1, '1, '1, '1, '1, '1, '1, '1);
			else if (p == 12) setup = '0;
			else setup = random_setup();
			program_regs(setup);
			ready_pattern = ready_pattern_t'(p % 4);
			gaps_on = (p % 3 != 2);
			for (n = 0; n < 30; n++) send_pixel(random_pixel());
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && backlog == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
